>>> rtl/lcd4w_pkg.sv
`default_nettype none

package lcd4w_pkg;

    // one request as it arrives
    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  row;
        logic [6:0]  column;
        logic [15:0] value;
    } req_t;

    // one enable strobe as it leaves
    typedef struct packed {
        logic [3:0] data_nibble;
        logic       register_select;
        logic [7:0] hold_ms;
        logic       number_valid;
        logic       last;
    } res_t;

    localparam logic [2:0] MODE_CMD     = 3'd0;
    localparam logic [2:0] MODE_DATA    = 3'd1;
    localparam logic [2:0] MODE_SET_POS = 3'd2;
    localparam logic [2:0] MODE_CHAR    = 3'd3;
    localparam logic [2:0] MODE_DIGIT   = 3'd4;
    localparam logic [2:0] MODE_NUMBER  = 3'd5;

    localparam logic [1:0] REG_FIRST_BASE  = 2'd0;
    localparam logic [1:0] REG_SECOND_BASE = 2'd1;
    localparam logic [1:0] REG_STROBE_HOLD = 2'd2;

    localparam logic [1:0] ROW_FIRST  = 2'd1;
    localparam logic [1:0] ROW_SECOND = 2'd2;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_NINE = 8'd57;

    // number is carried as a binary fraction value/10000 scaled by 2^FRAC_W;
    // each digit is then the integer part after a multiply by ten
    localparam int          FRAC_W    = 28;
    localparam logic [14:0] NUM_SCALE = 15'd26844;
    localparam logic [15:0] NUM_LIMIT = 16'd10000;

    // classified request, one queue entry
    typedef struct packed {
        logic              pos_en;
        logic [7:0]        pos_byte;
        logic              has_data;
        logic [7:0]        data_byte;
        logic              data_rs;
        logic              is_num;
        logic [FRAC_W-1:0] frac;
        logic              num_valid;
        logic [7:0]        hold;
    } job_t;

endpackage

`default_nettype wire

>>> rtl/lcd4w_front.sv
`default_nettype none

module lcd4w_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic              full,
    input  wire lcd4w_pkg::req_t   req,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    output logic                   wr_en,
    output lcd4w_pkg::job_t        job
);
    import lcd4w_pkg::*;

    logic [7:0]  first_base_reg;
    logic [7:0]  second_base_reg;
    logic [7:0]  hold_reg;

    logic [7:0]  byte_in;
    logic [7:0]  digit_byte;
    logic        row_ok;
    logic        num_ok;
    logic [28:0] num_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_base_reg  <= 8'd128;
            second_base_reg <= 8'd192;
            hold_reg        <= 8'd5;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FIRST_BASE:  first_base_reg  <= cfg_data;
                REG_SECOND_BASE: second_base_reg <= cfg_data;
                REG_STROBE_HOLD: hold_reg        <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign byte_in    = req.value[7:0];
    assign digit_byte = (byte_in < ASCII_ZERO || byte_in > ASCII_NINE) ? ASCII_ZERO : byte_in;
    assign row_ok     = (req.row == ROW_FIRST) || (req.row == ROW_SECOND);
    assign num_ok     = req.value < NUM_LIMIT;
    assign num_prod   = req.value[13:0] * NUM_SCALE;

    always_comb
    begin
        job           = '0;
        job.hold      = hold_reg;
        job.pos_byte  = ((req.row == ROW_SECOND) ? second_base_reg : first_base_reg)
                        | {1'b0, req.column};
        job.data_byte = byte_in;
        job.data_rs   = RS_DATA;
        job.frac      = num_ok ? num_prod[FRAC_W-1:0] : '0;
        unique case (req.mode)
            MODE_CMD:
            begin
                job.has_data = 1'b1;
                job.data_rs  = RS_CMD;
            end
            MODE_DATA:
            begin
                job.has_data = 1'b1;
            end
            MODE_SET_POS:
            begin
                job.pos_en = row_ok;
            end
            MODE_CHAR:
            begin
                job.pos_en   = row_ok;
                job.has_data = 1'b1;
            end
            MODE_DIGIT:
            begin
                job.pos_en    = row_ok;
                job.has_data  = 1'b1;
                job.data_byte = digit_byte;
            end
            MODE_NUMBER:
            begin
                job.pos_en    = row_ok;
                job.has_data  = 1'b1;
                job.is_num    = 1'b1;
                job.num_valid = num_ok;
            end
            default:
            begin
                job.pos_en   = 1'b0;
                job.has_data = 1'b0;
            end
        endcase
    end

    // requests that cause no strobe are dropped here
    assign wr_en = push && !full && (job.pos_en || job.has_data);

endmodule

`default_nettype wire

>>> rtl/lcd4w_fifo.sv
`default_nettype none

module lcd4w_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire lcd4w_pkg::job_t  wdata,
    output logic                  full,
    input  wire logic             rd,
    output lcd4w_pkg::job_t       rdata,
    output logic                  empty
);
    import lcd4w_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full  = count_reg == FULL_CNT;
    assign empty = count_reg == '0;
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/lcd4w_back.sv
`default_nettype none

module lcd4w_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_avail,
    input  wire lcd4w_pkg::job_t  job,
    output logic                  job_take,
    input  wire logic             pop,
    output logic                  empty,
    output lcd4w_pkg::res_t       res
);
    import lcd4w_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_POS_HI = 5'b00010,
        S_POS_LO = 5'b00100,
        S_DAT_HI = 5'b01000,
        S_DAT_LO = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    job_t              job_reg, job_next;
    logic [7:0]        byte_reg, byte_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [1:0]        left_reg, left_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic              out_ready;
    logic              emit;
    logic              load;
    logic [3:0]        nibble;
    logic              rs;
    logic              last_strobe;
    logic [FRAC_W-1:0] src_frac;
    logic [FRAC_W+3:0] prod10;
    logic [7:0]        step_byte;
    logic [FRAC_W-1:0] step_frac;

    assign out_ready = !out_valid_reg || pop;
    assign emit      = out_ready && (state_reg != S_IDLE);

    always_comb
    begin
        nibble      = '0;
        rs          = RS_CMD;
        last_strobe = 1'b0;
        unique case (state_reg)
            S_POS_HI: nibble = job_reg.pos_byte[7:4];
            S_POS_LO:
            begin
                nibble      = job_reg.pos_byte[3:0];
                last_strobe = !job_reg.has_data;
            end
            S_DAT_HI:
            begin
                nibble = byte_reg[7:4];
                rs     = job_reg.data_rs;
            end
            S_DAT_LO:
            begin
                nibble      = byte_reg[3:0];
                rs          = job_reg.data_rs;
                last_strobe = left_reg == 2'd0;
            end
            default: ;
        endcase
    end

    assign load     = (state_reg == S_IDLE) || (emit && last_strobe);
    assign job_take = load && job_avail;

    // next decimal digit: times ten, integer part out
    assign src_frac  = load ? job.frac : frac_reg;
    assign prod10    = ({4'b0, src_frac} << 3) + ({4'b0, src_frac} << 1);
    assign step_byte = ASCII_ZERO | {4'b0, prod10[FRAC_W+3:FRAC_W]};
    assign step_frac = prod10[FRAC_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        byte_next  = byte_reg;
        frac_next  = frac_reg;
        left_next  = left_reg;
        priority if (load)
        begin
            if (job_avail)
            begin
                job_next = job;
                if (job.pos_en)
                begin
                    state_next = S_POS_HI;
                    frac_next  = job.frac;
                end
                else
                begin
                    state_next = S_DAT_HI;
                    byte_next  = job.is_num ? step_byte : job.data_byte;
                    frac_next  = step_frac;
                    left_next  = job.is_num ? 2'd3 : 2'd0;
                end
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
        else if (emit)
        begin
            unique case (state_reg)
                S_POS_HI: state_next = S_POS_LO;
                S_POS_LO:
                begin
                    state_next = S_DAT_HI;
                    byte_next  = job_reg.is_num ? step_byte : job_reg.data_byte;
                    frac_next  = step_frac;
                    left_next  = job_reg.is_num ? 2'd3 : 2'd0;
                end
                S_DAT_HI: state_next = S_DAT_LO;
                S_DAT_LO:
                begin
                    state_next = S_DAT_HI;
                    byte_next  = step_byte;
                    frac_next  = step_frac;
                    left_next  = left_reg - 2'd1;
                end
                default: state_next = S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next           = 1'b1;
            out_next.data_nibble     = nibble;
            out_next.register_select = rs;
            out_next.hold_ms         = job_reg.hold;
            out_next.number_valid    = job_reg.num_valid;
            out_next.last            = last_strobe;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        byte_reg <= byte_next;
        frac_reg <= frac_next;
        left_reg <= left_next;
        out_reg  <= out_next;
    end

    assign empty = !out_valid_reg;
    assign res   = out_reg;

endmodule

`default_nettype wire

>>> rtl/char_lcd_4bit_writer.sv
// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+---------------------------
// request   | in        | push / full                  | req (mode,row,column,value)
// strobe    | out       | pop / empty                  | res (nibble,rs,hold,valid,last)
// config    | in        | cfg_write (no wait)          | cfg_index, cfg_data
//
// One strobe leaves per cycle while pop is held; a request gives 2 to 10 strobes,
// set by the strobe sequencer in the back end.
// Requests are classified on the way in and wait in a QUEUE_DEPTH-entry queue,
// so intake continues while the result register is stalled.
// Reset clears the queue, the sequencer and the result register; the line bases
// and hold time return to 128, 192 and 5.
`default_nettype none

module char_lcd_4bit_writer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire lcd4w_pkg::req_t  req,
    input  wire logic             pop,
    output logic                  empty,
    output lcd4w_pkg::res_t       res,
    input  wire logic             cfg_write,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [7:0]       cfg_data
);
    import lcd4w_pkg::*;

    logic wr_en;
    job_t wr_job;
    job_t head_job;
    logic q_empty;
    logic job_take;

    lcd4w_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .job       (wr_job)
    );

    lcd4w_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr_en),
        .wdata (wr_job),
        .full  (full),
        .rd    (job_take),
        .rdata (head_job),
        .empty (q_empty)
    );

    lcd4w_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!q_empty),
        .job       (head_job),
        .job_take  (job_take),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

endmodule

`default_nettype wire

>>> rtl/lcd4w_checker.sv
`default_nettype none

module lcd4w_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             pop,
    input wire logic             empty,
    input wire lcd4w_pkg::res_t  res
);
    import lcd4w_pkg::*;

    // nothing to show while held in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    // a stalled strobe holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(res))
        else $error("stalled strobe changed");

    // strobes of one transaction follow without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !res.last |=> !empty)
        else $error("gap inside a transaction");

    // hold time and valid flag stay fixed within a transaction
    a_same_req: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && !res.last |=>
            res.hold_ms == $past(res.hold_ms) && res.number_valid == $past(res.number_valid))
        else $error("strobe fields changed inside a transaction");

endmodule

bind char_lcd_4bit_writer lcd4w_checker u_checker (.*);

`default_nettype wire
